### rtl/clip_path_record_decoder_unit_defines.svh
// ----------------------------------------------------------------------------
// Clip path record decoder - assertion macros
// Shared property forms for the port checker of the decoder.
// ----------------------------------------------------------------------------
`ifndef CLIP_PATH_RECORD_DECODER_UNIT_DEFINES_SVH
`define CLIP_PATH_RECORD_DECODER_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on the rising edge, off during reset.
`define CLPD_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on the rising edge, off during reset.
`define CLPD_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/clpd_pkg.sv
// ----------------------------------------------------------------------------
// Clip path record decoder - package
// Word types, segment codes, record selectors and configuration indexes.
// ----------------------------------------------------------------------------
`default_nettype none

package clpd_pkg;

  localparam int unsigned QUEUE_DEPTH = 4;

  // Record selectors
  localparam logic [15:0] REC_COUNT_CLOSED = 16'd0;
  localparam logic [15:0] REC_KNOT_CLOSED_LINKED = 16'd1;
  localparam logic [15:0] REC_KNOT_CLOSED_FREE = 16'd2;
  localparam logic [15:0] REC_COUNT_OPEN = 16'd3;
  localparam logic [15:0] REC_KNOT_OPEN_LINKED = 16'd4;
  localparam logic [15:0] REC_KNOT_OPEN_FREE = 16'd5;

  // Configuration register indexes
  localparam logic CFG_IMAGE_WIDTH = 1'b0;
  localparam logic CFG_IMAGE_HEIGHT = 1'b1;

  typedef enum logic [2:0] {
    SEG_MOVE   = 3'd0,
    SEG_LINE   = 3'd1,
    SEG_QUAD   = 3'd2,
    SEG_SMOOTH = 3'd3,
    SEG_CUBIC  = 3'd4
  } clpd_seg_kind_t;

  typedef struct packed {
    logic               new_block;
    logic [15:0]        record_kind;
    logic signed [15:0] knot_total;
    logic signed [31:0] before_y;
    logic signed [31:0] before_x;
    logic signed [31:0] anchor_y;
    logic signed [31:0] anchor_x;
    logic signed [31:0] after_y;
    logic signed [31:0] after_x;
  } clpd_record_t;

  typedef struct packed {
    clpd_seg_kind_t     segment_kind;
    logic               closes_path;
    logic signed [47:0] ctrl_a_x;
    logic signed [47:0] ctrl_a_y;
    logic signed [47:0] ctrl_b_x;
    logic signed [47:0] ctrl_b_y;
    logic signed [47:0] end_x;
    logic signed [47:0] end_y;
    logic               last_of_run;
  } clpd_segment_t;

  // Unscaled segment command passed from the front end to the scaler
  typedef struct packed {
    clpd_seg_kind_t     kind;
    logic               closes;
    logic               last;
    logic signed [31:0] a_x;
    logic signed [31:0] a_y;
    logic signed [31:0] b_x;
    logic signed [31:0] b_y;
    logic signed [31:0] e_x;
    logic signed [31:0] e_y;
  } clpd_seg_cmd_t;

endpackage

`default_nettype wire

### rtl/clpd_front.sv
// ----------------------------------------------------------------------------
// Clip path record decoder - front end
// Accepts records, tracks subpath state and issues unscaled segment commands.
// ----------------------------------------------------------------------------
`default_nettype none

module clpd_front (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   record_valid,
  output logic                        record_stall,
  input  wire clpd_pkg::clpd_record_t record,
  input  wire logic                   width_zero,
  input  wire logic                   height_zero,
  input  wire logic                   queue_full,
  output logic                        push_valid,
  output clpd_pkg::clpd_seg_cmd_t     push_data
);

  // Points compare equal after scaling when the scale is zero or raw bits match
  function automatic logic pt_eq(input logic [31:0] px, input logic [31:0] py,
                                 input logic [31:0] qx, input logic [31:0] qy,
                                 input logic wz, input logic hz);
    pt_eq = (wz || (px == qx)) && (hz || (py == qy));
  endfunction

  function automatic clpd_pkg::clpd_seg_cmd_t make_seg(
      input logic [31:0] pax, input logic [31:0] pay,
      input logic [31:0] pfx, input logic [31:0] pfy,
      input logic [31:0] bx, input logic [31:0] by,
      input logic [31:0] ax, input logic [31:0] ay,
      input logic wz, input logic hz, input logic closing, input logic last);
    clpd_pkg::clpd_seg_cmd_t c;
    logic prev_flat;
    logic cur_flat;
    prev_flat = pt_eq(pax, pay, pfx, pfy, wz, hz);
    cur_flat = pt_eq(bx, by, ax, ay, wz, hz);
    c = '0;
    c.closes = closing;
    c.last = last;
    if (prev_flat && cur_flat) begin
      c.kind = clpd_pkg::SEG_LINE;
    end else if (prev_flat) begin
      c.kind = clpd_pkg::SEG_QUAD;
      c.a_x = bx;
      c.a_y = by;
    end else begin
      c.a_x = pfx;
      c.a_y = pfy;
      if (cur_flat) begin
        c.kind = clpd_pkg::SEG_SMOOTH;
      end else begin
        c.kind = clpd_pkg::SEG_CUBIC;
        c.b_x = bx;
        c.b_y = by;
      end
    end
    c.e_x = ax;
    c.e_y = ay;
    make_seg = c;
  endfunction

  logic [15:0]             knots_left;
  logic                    subpath_open;
  logic [31:0]             first_pts [4];
  logic [31:0]             prev_pts [4];
  logic                    pend_valid;
  clpd_pkg::clpd_seg_cmd_t pend_cmd;

  logic                    accept;
  logic [15:0]             kl_eff;
  logic [15:0]             kl_dec;
  logic [15:0]             knots_left_next;
  logic                    open_eff;
  logic                    is_count;
  logic                    is_knot;
  logic                    knot_go;
  logic                    closing_now;
  logic [31:0]             first_new [4];
  clpd_pkg::clpd_seg_cmd_t first_cmd;
  clpd_pkg::clpd_seg_cmd_t close_cmd;

  always_comb begin
    record_stall = pend_valid || queue_full;
    accept = record_valid && !record_stall;

    // A new block clears path state ahead of the record
    kl_eff = record.new_block ? 16'd0 : knots_left;
    open_eff = record.new_block ? 1'b0 : subpath_open;
    kl_dec = kl_eff - 16'd1;

    is_count = record.record_kind inside {clpd_pkg::REC_COUNT_CLOSED,
                                          clpd_pkg::REC_COUNT_OPEN};
    is_knot = record.record_kind inside {clpd_pkg::REC_KNOT_CLOSED_LINKED,
                                         clpd_pkg::REC_KNOT_CLOSED_FREE,
                                         clpd_pkg::REC_KNOT_OPEN_LINKED,
                                         clpd_pkg::REC_KNOT_OPEN_FREE};
    knot_go = is_knot && (kl_eff != 16'd0);
    closing_now = knot_go && (kl_dec == 16'd0);

    if (is_count) begin
      if (kl_eff == 16'd0) begin
        knots_left_next = record.knot_total[15] ? 16'd0 : record.knot_total;
      end else begin
        knots_left_next = kl_eff;
      end
    end else if (knot_go) begin
      knots_left_next = kl_dec;
    end else begin
      knots_left_next = kl_eff;
    end

    if (open_eff) begin
      first_new = first_pts;
      first_cmd = make_seg(prev_pts[0], prev_pts[1], prev_pts[2], prev_pts[3],
                           record.before_x, record.before_y,
                           record.anchor_x, record.anchor_y,
                           width_zero, height_zero, 1'b0, !closing_now);
    end else begin
      first_new[0] = record.before_x;
      first_new[1] = record.before_y;
      first_new[2] = record.anchor_x;
      first_new[3] = record.anchor_y;
      first_cmd = '0;
      first_cmd.kind = clpd_pkg::SEG_MOVE;
      first_cmd.last = !closing_now;
      first_cmd.e_x = record.anchor_x;
      first_cmd.e_y = record.anchor_y;
    end

    // Closing segment runs from this knot back to the first anchor
    close_cmd = make_seg(record.anchor_x, record.anchor_y,
                         record.after_x, record.after_y,
                         first_new[0], first_new[1], first_new[2], first_new[3],
                         width_zero, height_zero, 1'b1, 1'b1);

    push_valid = pend_valid ? !queue_full : (accept && knot_go);
    push_data = pend_valid ? pend_cmd : first_cmd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      knots_left <= '0;
      subpath_open <= 1'b0;
      pend_valid <= 1'b0;
    end else begin
      if (pend_valid && !queue_full) begin
        pend_valid <= 1'b0;
      end
      if (accept) begin
        knots_left <= knots_left_next;
        subpath_open <= knot_go ? !closing_now : open_eff;
        if (closing_now) begin
          pend_valid <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && knot_go) begin
      first_pts <= first_new;
      prev_pts[0] <= record.anchor_x;
      prev_pts[1] <= record.anchor_y;
      prev_pts[2] <= record.after_x;
      prev_pts[3] <= record.after_y;
    end
    if (accept && closing_now) begin
      pend_cmd <= close_cmd;
    end
  end

endmodule

`default_nettype wire

### rtl/clpd_queue.sv
// ----------------------------------------------------------------------------
// Clip path record decoder - command queue
// Small register FIFO between the front end and the scaler.
// ----------------------------------------------------------------------------
`default_nettype none

module clpd_queue #(
  parameter int unsigned Depth = clpd_pkg::QUEUE_DEPTH
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    push_valid,
  input  wire clpd_pkg::clpd_seg_cmd_t push_data,
  output logic                         full,
  input  wire logic                    pop,
  output logic                         not_empty,
  output clpd_pkg::clpd_seg_cmd_t      pop_data
);

  localparam int unsigned IdxW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  clpd_pkg::clpd_seg_cmd_t entries [Depth];
  logic [IdxW-1:0]         wr_ptr;
  logic [IdxW-1:0]         rd_ptr;
  logic [CntW-1:0]         count;
  logic                    do_push;
  logic                    do_pop;

  always_comb begin
    full = (count == CntW'(Depth));
    not_empty = (count != '0);
    do_push = push_valid && !full;
    do_pop = pop && not_empty;
    pop_data = entries[rd_ptr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == IdxW'(Depth - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == IdxW'(Depth - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_data;
    end
  end

endmodule

`default_nettype wire

### rtl/clpd_back.sv
// ----------------------------------------------------------------------------
// Clip path record decoder - scaler
// Scales command coordinates to pixels and holds the result word.
// ----------------------------------------------------------------------------
`default_nettype none

module clpd_back (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    cmd_valid,
  input  wire clpd_pkg::clpd_seg_cmd_t cmd,
  output logic                         cmd_pop,
  input  wire logic [15:0]             image_width,
  input  wire logic [15:0]             image_height,
  output logic                         segment_valid,
  input  wire logic                    segment_stall,
  output clpd_pkg::clpd_segment_t      segment
);

  function automatic logic signed [47:0] scale(input logic signed [31:0] v,
                                                input logic [15:0] s);
    logic signed [48:0] p;
    p = v * $signed({1'b0, s});
    scale = p[47:0];
  endfunction

  clpd_pkg::clpd_segment_t seg_next;

  always_comb begin
    cmd_pop = cmd_valid && (!segment_valid || !segment_stall);
    seg_next.segment_kind = cmd.kind;
    seg_next.closes_path = cmd.closes;
    seg_next.last_of_run = cmd.last;
    seg_next.ctrl_a_x = scale(cmd.a_x, image_width);
    seg_next.ctrl_a_y = scale(cmd.a_y, image_height);
    seg_next.ctrl_b_x = scale(cmd.b_x, image_width);
    seg_next.ctrl_b_y = scale(cmd.b_y, image_height);
    seg_next.end_x = scale(cmd.e_x, image_width);
    seg_next.end_y = scale(cmd.e_y, image_height);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      segment_valid <= 1'b0;
    end else if (cmd_pop) begin
      segment_valid <= 1'b1;
    end else if (!segment_stall) begin
      segment_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      segment <= seg_next;
    end
  end

endmodule

`default_nettype wire

### rtl/clip_path_record_decoder_unit.sv
// ----------------------------------------------------------------------------
// Clip path record decoder - top level
// Turns path records with 8.24 knots into move, line and curve segment words.
// ----------------------------------------------------------------------------
// Each record word carries a selector, a knot count and three signed 8.24
// points. Count records arm a subpath; knot records give one segment word
// each (a move for the first knot), and the last knot of a subpath gives a
// second, closing word back to the first anchor. Coordinates leave as 48-bit
// pixels with 24 fraction bits, scaled by image_width and image_height. A
// record that yields zero or one word is taken every cycle while the queue
// has room; one that closes a subpath holds the record side until its
// closing word is written, as the front end writes one word per cycle into
// the command queue; the scaler registers each word. No clearing pass after
// reset. Write image_width and image_height only while the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module clip_path_record_decoder_unit #(
  parameter int unsigned QueueDepth = clpd_pkg::QUEUE_DEPTH
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   cfg_write,
  input  wire logic                   cfg_index,
  input  wire logic [15:0]            cfg_data,
  input  wire logic                   record_valid,
  output logic                        record_stall,
  input  wire clpd_pkg::clpd_record_t record,
  output logic                        segment_valid,
  input  wire logic                   segment_stall,
  output clpd_pkg::clpd_segment_t     segment
);

  logic [15:0]             image_width;
  logic [15:0]             image_height;

  logic                    push_valid;
  clpd_pkg::clpd_seg_cmd_t push_data;
  logic                    queue_full;
  logic                    queue_pop;
  logic                    queue_not_empty;
  clpd_pkg::clpd_seg_cmd_t queue_data;

  // Hold the scale registers; reset to unit scale
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width <= 16'd1;
      image_height <= 16'd1;
    end else if (cfg_write) begin
      case (cfg_index)
        clpd_pkg::CFG_IMAGE_WIDTH: image_width <= cfg_data;
        clpd_pkg::CFG_IMAGE_HEIGHT: image_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // Front end: classify records, advance the knot count, build commands
  clpd_front u_front (
    .clk          (clk),
    .rst          (rst),
    .record_valid (record_valid),
    .record_stall (record_stall),
    .record       (record),
    .width_zero   (image_width == 16'd0),
    .height_zero  (image_height == 16'd0),
    .queue_full   (queue_full),
    .push_valid   (push_valid),
    .push_data    (push_data)
  );

  // Decouple the two sides so each can stall on its own
  clpd_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_data  (push_data),
    .full       (queue_full),
    .pop        (queue_pop),
    .not_empty  (queue_not_empty),
    .pop_data   (queue_data)
  );

  // Back end: scale to pixels and drive the segment word
  clpd_back u_back (
    .clk           (clk),
    .rst           (rst),
    .cmd_valid     (queue_not_empty),
    .cmd           (queue_data),
    .cmd_pop       (queue_pop),
    .image_width   (image_width),
    .image_height  (image_height),
    .segment_valid (segment_valid),
    .segment_stall (segment_stall),
    .segment       (segment)
  );

endmodule

`default_nettype wire

### rtl/clpd_checker.sv
// ----------------------------------------------------------------------------
// Clip path record decoder - port checker
// Watches the segment word channel of the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "clip_path_record_decoder_unit_defines.svh"

module clpd_checker (
  input wire logic                    clk,
  input wire logic                    rst,
  input wire logic                    segment_valid,
  input wire logic                    segment_stall,
  input wire clpd_pkg::clpd_segment_t segment
);

  `CLPD_ASSERT_NEXT(a_stalled_word_holds, clk, rst, segment_valid && segment_stall, segment_valid && $stable(segment), "stalled segment word changed")

  `CLPD_ASSERT_NOW(a_close_ends_run, clk, rst, segment_valid && segment.closes_path, segment.last_of_run && (segment.segment_kind != clpd_pkg::SEG_MOVE), "closing word not last or is a move")

  `CLPD_ASSERT_NOW(a_move_no_ctrl, clk, rst, segment_valid && (segment.segment_kind == clpd_pkg::SEG_MOVE), (segment.ctrl_a_x == '0) && (segment.ctrl_a_y == '0) && (segment.ctrl_b_x == '0) && (segment.ctrl_b_y == '0), "move carries control points")

  `CLPD_ASSERT_NOW(a_line_no_ctrl, clk, rst, segment_valid && (segment.segment_kind == clpd_pkg::SEG_LINE), (segment.ctrl_a_x == '0) && (segment.ctrl_a_y == '0) && (segment.ctrl_b_x == '0) && (segment.ctrl_b_y == '0), "line carries control points")

endmodule

bind clip_path_record_decoder_unit clpd_checker u_clpd_checker (.*);

`default_nettype wire

### tb/tb_clip_path_record_decoder_unit.sv
// ----------------------------------------------------------------------------
// Clip path record decoder - testbench
// Drives path record words into the decoder and checks every segment word it
// returns against a cycle-free model of the decoder kept in this file. A short
// directed part covers every segment shape, the extreme coordinates and the
// records the decoder must ignore. Random subpaths then follow under several
// scale settings, with random gaps and stalls on both sides, one long stall
// of the segment side, and sender pauses until all segment words are back.
// ----------------------------------------------------------------------------
module tb_clip_path_record_decoder_unit;
  import clpd_pkg::*;

  // Drain time once nothing is outstanding
  localparam int SETTLE_CYCLES = 8;
  // Length of the long hold-off on the segment side
  localparam int HOLD_OFF_CYCLES = 120;

  localparam logic signed [31:0] COORD_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] COORD_MIN = 32'sh8000_0000;

  // Selectors the decoder must skip
  localparam logic [15:0] REC_UNKNOWN_LOW = 16'd6;
  localparam logic [15:0] REC_UNKNOWN_TOP = 16'hFFFF;

  logic          clk;
  logic          rst = 1'b1;
  logic          cfg_write = 1'b0;
  logic          cfg_index = CFG_IMAGE_WIDTH;
  logic [15:0]   cfg_data = '0;
  logic          record_valid = 1'b0;
  logic          record_stall;
  clpd_record_t  record = '0;
  logic          segment_valid;
  logic          segment_stall = 1'b0;
  clpd_segment_t segment;

  // Model state: scale registers and path state of the decoder
  logic [15:0]        scale_w = 16'd1;
  logic [15:0]        scale_h = 16'd1;
  logic [15:0]        knots_pending = '0;
  logic               path_open = 1'b0;
  logic signed [31:0] head_before_x = '0, head_before_y = '0;
  logic signed [31:0] head_anchor_x = '0, head_anchor_y = '0;
  logic signed [31:0] prior_anchor_x = '0, prior_anchor_y = '0;
  logic signed [31:0] prior_after_x = '0, prior_after_y = '0;

  // Segment words predicted but not yet seen, oldest first
  clpd_segment_t segments_due[$];

  int failures = 0;
  bit idling_on = 1'b1;
  bit hold_request = 1'b0;
  bit hold_active = 1'b0;

  clip_path_record_decoder_unit uut (
    .clk           (clk),
    .rst           (rst),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .record_valid  (record_valid),
    .record_stall  (record_stall),
    .record        (record),
    .segment_valid (segment_valid),
    .segment_stall (segment_stall),
    .segment       (segment)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Model of the decoder
  // --------------------------------------------------------------------------

  // Exact product of an 8.24 fraction and a pixel size: pixels, 24 fraction bits
  function automatic logic signed [47:0] to_pixels(input logic signed [31:0] coord,
                                                   input logic [15:0] size);
    longint product;
    product = longint'(coord) * longint'(size);
    return product[47:0];
  endfunction

  // Points are compared after scaling, so a zero size makes them all equal
  function automatic bit same_point(input logic signed [31:0] ax, ay, bx, by);
    return to_pixels(ax, scale_w) == to_pixels(bx, scale_w) &&
           to_pixels(ay, scale_h) == to_pixels(by, scale_h);
  endfunction

  function automatic void clear_path();
    knots_pending = '0;
    path_open = 1'b0;
    head_before_x = '0;
    head_before_y = '0;
    head_anchor_x = '0;
    head_anchor_y = '0;
    prior_anchor_x = '0;
    prior_anchor_y = '0;
    prior_after_x = '0;
    prior_after_y = '0;
  endfunction

  // Segment from the previous knot to a knot given by its incoming control and
  // anchor; the shape follows from which of the two ends is flat
  function automatic clpd_segment_t segment_to(input logic signed [31:0] ctrl_x, ctrl_y,
                                               end_x, end_y, input bit closing);
    clpd_segment_t seg;
    bit prior_flat;
    bit end_flat;
    prior_flat = same_point(prior_anchor_x, prior_anchor_y, prior_after_x, prior_after_y);
    end_flat = same_point(ctrl_x, ctrl_y, end_x, end_y);
    seg = '0;
    seg.closes_path = closing;
    if (prior_flat && end_flat) begin
      seg.segment_kind = SEG_LINE;
    end else if (prior_flat) begin
      seg.segment_kind = SEG_QUAD;
      seg.ctrl_a_x = to_pixels(ctrl_x, scale_w);
      seg.ctrl_a_y = to_pixels(ctrl_y, scale_h);
    end else begin
      seg.ctrl_a_x = to_pixels(prior_after_x, scale_w);
      seg.ctrl_a_y = to_pixels(prior_after_y, scale_h);
      if (end_flat) begin
        seg.segment_kind = SEG_SMOOTH;
      end else begin
        seg.segment_kind = SEG_CUBIC;
        seg.ctrl_b_x = to_pixels(ctrl_x, scale_w);
        seg.ctrl_b_y = to_pixels(ctrl_y, scale_h);
      end
    end
    seg.end_x = to_pixels(end_x, scale_w);
    seg.end_y = to_pixels(end_y, scale_h);
    return seg;
  endfunction

  // Advance the model by one accepted record and queue the words it causes
  function automatic void predict_record(input clpd_record_t rec);
    clpd_segment_t seg;
    clpd_segment_t closing_seg;
    if (rec.new_block)
      clear_path();
    if (rec.record_kind == REC_COUNT_CLOSED || rec.record_kind == REC_COUNT_OPEN) begin
      // a count only arms an idle path; a negative count arms nothing
      if (knots_pending == 0)
        knots_pending = rec.knot_total[15] ? 16'd0 : rec.knot_total;
      return;
    end
    if (!(rec.record_kind == REC_KNOT_CLOSED_LINKED || rec.record_kind == REC_KNOT_CLOSED_FREE ||
          rec.record_kind == REC_KNOT_OPEN_LINKED || rec.record_kind == REC_KNOT_OPEN_FREE))
      return;
    if (knots_pending == 0)
      return;

    if (!path_open) begin
      seg = '0;
      seg.segment_kind = SEG_MOVE;
      seg.end_x = to_pixels(rec.anchor_x, scale_w);
      seg.end_y = to_pixels(rec.anchor_y, scale_h);
      head_before_x = rec.before_x;
      head_before_y = rec.before_y;
      head_anchor_x = rec.anchor_x;
      head_anchor_y = rec.anchor_y;
    end else begin
      seg = segment_to(rec.before_x, rec.before_y, rec.anchor_x, rec.anchor_y, 1'b0);
    end
    prior_anchor_x = rec.anchor_x;
    prior_anchor_y = rec.anchor_y;
    prior_after_x = rec.after_x;
    prior_after_y = rec.after_y;
    path_open = 1'b1;
    knots_pending = knots_pending - 16'd1;

    if (knots_pending == 0) begin
      // last knot: close back onto the first one, judged against this knot
      segments_due.push_back(seg);
      closing_seg = segment_to(head_before_x, head_before_y, head_anchor_x, head_anchor_y, 1'b1);
      closing_seg.last_of_run = 1'b1;
      segments_due.push_back(closing_seg);
      path_open = 1'b0;
    end else begin
      seg.last_of_run = 1'b1;
      segments_due.push_back(seg);
    end
  endfunction

  // --------------------------------------------------------------------------
  // Segment side: pacing and checking
  // --------------------------------------------------------------------------

  // Stall at random: short ready and stall runs, now and then a long stall,
  // none while idling is off, and one long hold-off on request
  initial begin : segment_pacing
    int ready_run;
    int stall_run;
    @(posedge clk);
    forever begin
      if (hold_request) begin
        hold_active = 1'b1;
        segment_stall <= 1'b1;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        hold_request = 1'b0;
        hold_active = 1'b0;
      end
      ready_run = $urandom_range(0, 6);
      if (!idling_on)
        stall_run = 0;
      else if ($urandom_range(0, 11) == 0)
        stall_run = $urandom_range(10, 40);
      else
        stall_run = $urandom_range(0, 3);
      segment_stall <= 1'b0;
      repeat (ready_run + 1) @(posedge clk);
      if (stall_run > 0) begin
        segment_stall <= 1'b1;
        repeat (stall_run) @(posedge clk);
      end
    end
  end

  function automatic void check_field(input string field, input logic [47:0] want,
                                      input logic [47:0] got);
    if (got !== want) begin
      $error("%s: expected %h, got %h", field, want, got);
      failures++;
    end
  endfunction

  // Compare each accepted segment word with the oldest prediction
  always @(posedge clk) begin : segment_checker
    clpd_segment_t want;
    if (!rst && segment_valid && !segment_stall) begin
      if (segments_due.size() == 0) begin
        $error("segment word with none expected: %h", segment);
        failures++;
      end else begin
        want = segments_due.pop_front();
        check_field("segment_kind", 48'(want.segment_kind), 48'(segment.segment_kind));
        check_field("closes_path", 48'(want.closes_path), 48'(segment.closes_path));
        check_field("ctrl_a_x", want.ctrl_a_x, segment.ctrl_a_x);
        check_field("ctrl_a_y", want.ctrl_a_y, segment.ctrl_a_y);
        check_field("ctrl_b_x", want.ctrl_b_x, segment.ctrl_b_x);
        check_field("ctrl_b_y", want.ctrl_b_y, segment.ctrl_b_y);
        check_field("end_x", want.end_x, segment.end_x);
        check_field("end_y", want.end_y, segment.end_y);
        check_field("last_of_run", 48'(want.last_of_run), 48'(segment.last_of_run));
      end
    end
  end

  // --------------------------------------------------------------------------
  // Record side: word builders and driving
  // --------------------------------------------------------------------------

  // Mostly small fractions, some full-range values and the two extremes
  function automatic logic signed [31:0] rand_coord();
    case ($urandom_range(0, 7))
      0:       return COORD_MAX;
      1:       return COORD_MIN;
      2, 3:    return $urandom;
      default: return 32'($urandom_range(0, 32'h01FF_FFFF)) - 32'h0100_0000;
    endcase
  endfunction

  function automatic clpd_record_t random_record();
    clpd_record_t rec;
    rec.new_block = ($urandom_range(0, 7) == 0);
    rec.record_kind = $urandom_range(0, 1) ? 16'($urandom_range(0, 7)) : 16'($urandom);
    rec.knot_total = 16'($urandom);
    rec.before_y = rand_coord();
    rec.before_x = rand_coord();
    rec.anchor_y = rand_coord();
    rec.anchor_x = rand_coord();
    rec.after_y = rand_coord();
    rec.after_x = rand_coord();
    return rec;
  endfunction

  function automatic clpd_record_t count_record(input bit fresh, input logic [15:0] kind,
                                                input logic signed [15:0] total);
    clpd_record_t rec;
    rec = random_record();
    rec.new_block = fresh;
    rec.record_kind = kind;
    rec.knot_total = total;
    return rec;
  endfunction

  function automatic clpd_record_t knot_record(input logic [15:0] kind,
                                               input logic signed [31:0] bx, by, ax, ay, fx, fy);
    clpd_record_t rec;
    rec = random_record();
    rec.new_block = 1'b0;
    rec.record_kind = kind;
    rec.before_x = bx;
    rec.before_y = by;
    rec.anchor_x = ax;
    rec.anchor_y = ay;
    rec.after_x = fx;
    rec.after_y = fy;
    return rec;
  endfunction

  // Random knot; each control sits on the anchor with the given odds,
  // otherwise it is random or misses the anchor by one step
  function automatic clpd_record_t random_knot(input int flat_pct);
    clpd_record_t rec;
    rec = random_record();
    rec.new_block = 1'b0;
    case ($urandom_range(0, 3))
      0:       rec.record_kind = REC_KNOT_CLOSED_LINKED;
      1:       rec.record_kind = REC_KNOT_CLOSED_FREE;
      2:       rec.record_kind = REC_KNOT_OPEN_LINKED;
      default: rec.record_kind = REC_KNOT_OPEN_FREE;
    endcase
    if ($urandom_range(0, 99) < flat_pct) begin
      rec.before_x = rec.anchor_x;
      rec.before_y = rec.anchor_y;
    end else if ($urandom_range(0, 3) == 0) begin
      rec.before_x = rec.anchor_x;
      rec.before_y = rec.anchor_y + 1;
    end
    if ($urandom_range(0, 99) < flat_pct) begin
      rec.after_x = rec.anchor_x;
      rec.after_y = rec.anchor_y;
    end else if ($urandom_range(0, 3) == 0) begin
      rec.after_x = rec.anchor_x - 1;
      rec.after_y = rec.anchor_y;
    end
    return rec;
  endfunction

  function automatic int pick_path_length();
    int roll;
    roll = $urandom_range(0, 19);
    if (roll < 14)
      return $urandom_range(1, 4);
    else if (roll < 19)
      return $urandom_range(5, 10);
    else
      return $urandom_range(11, 40);
  endfunction

  // Offer one record word after a random gap, hold it until taken, then
  // advance the model. Valid stays high on return so that back-to-back words
  // need no second assignment in the same step; wait_drain lowers it.
  task automatic send_record(input clpd_record_t rec);
    int gap;
    if (!idling_on)
      gap = 0;
    else if ($urandom_range(0, 15) == 0)
      gap = $urandom_range(8, 30);
    else
      gap = $urandom_range(0, 2);
    if (gap > 0) begin
      record_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    record <= rec;
    record_valid <= 1'b1;
    do @(posedge clk); while (record_stall);
    predict_record(rec);
  endtask

  // Drop valid and wait until every predicted word is back, then let the
  // pipeline settle
  task automatic wait_drain();
    record_valid <= 1'b0;
    @(posedge clk);
    while (segments_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(input logic idx, input logic [15:0] value);
    cfg_index <= idx;
    cfg_data <= value;
    cfg_write <= 1'b1;
    @(posedge clk);
    if (idx == CFG_IMAGE_WIDTH)
      scale_w = value;
    else
      scale_h = value;
    cfg_write <= 1'b0;
    @(posedge clk);
  endtask

  // Change the scale only once the decoder has gone idle
  task automatic set_scale(input logic [15:0] width, input logic [15:0] height);
    wait_drain();
    write_register(CFG_IMAGE_WIDTH, width);
    write_register(CFG_IMAGE_HEIGHT, height);
  endtask

  // Count word then the knots of one subpath; now and then slip in a word the
  // decoder must ignore (unknown selector, or a count while busy)
  task automatic send_subpath(input int knots, input int flat_pct, output int sent);
    clpd_record_t rec;
    sent = 0;
    rec = count_record(knots_pending != 0 || $urandom_range(0, 3) == 0,
                       $urandom_range(0, 1) ? REC_COUNT_OPEN : REC_COUNT_CLOSED, 16'(knots));
    send_record(rec);
    sent++;
    for (int k = 0; k < knots; k++) begin
      if ($urandom_range(0, 19) == 0) begin
        rec = random_record();
        rec.new_block = 1'b0;
        rec.record_kind = $urandom_range(0, 1) ?
                          16'($urandom_range(REC_UNKNOWN_LOW, REC_UNKNOWN_TOP)) : REC_COUNT_OPEN;
        send_record(rec);
      end
      send_record(random_knot(flat_pct));
      sent++;
    end
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // One subpath giving move, quadratic, line, smooth and cubic, then a smooth
  // close, at the reset scale of one pixel
  task automatic test_directed_shapes();
    send_record(count_record(1'b1, REC_COUNT_CLOSED, 16'sd5));
    // flat first knot at the origin: move
    send_record(knot_record(REC_KNOT_CLOSED_LINKED, 0, 0, 0, 0, 0, 0));
    // flat leaving side, control on the arriving side: quadratic
    send_record(knot_record(REC_KNOT_CLOSED_FREE, -1, 1, COORD_MAX, COORD_MIN,
                            COORD_MAX, COORD_MIN));
    // flat on both sides: line
    send_record(knot_record(REC_KNOT_OPEN_LINKED, COORD_MIN, COORD_MAX, COORD_MIN, COORD_MAX,
                            32'sh0100_0000, -32'sh0100_0000));
    // control leaving the previous knot, this one arrives flat: smooth
    send_record(knot_record(REC_KNOT_OPEN_FREE, -1, -1, -1, -1, 5, 6));
    // controls on both sides: cubic; the close onto the flat first knot is smooth
    send_record(knot_record(REC_KNOT_CLOSED_LINKED, COORD_MAX, COORD_MIN,
                            32'sh0080_0000, 32'sh0040_0000, 123, -456));
    wait_drain();
  endtask

  // Records the decoder must skip or treat specially
  task automatic test_special_cases();
    clpd_record_t rec;
    // negative counts arm nothing, so the knots after them are dropped
    send_record(count_record(1'b1, REC_COUNT_OPEN, -16'sd1));
    send_record(knot_record(REC_KNOT_OPEN_FREE, 1, 2, 3, 4, 5, 6));
    send_record(count_record(1'b0, REC_COUNT_CLOSED, 16'sh8000));
    send_record(knot_record(REC_KNOT_CLOSED_FREE, 7, 8, 9, 10, 11, 12));
    // zero count and unknown selectors
    send_record(count_record(1'b0, REC_COUNT_CLOSED, 16'sd0));
    send_record(count_record(1'b0, REC_UNKNOWN_TOP, 16'sd3));
    send_record(count_record(1'b0, REC_UNKNOWN_LOW, 16'sd3));
    // two knots; a second count while busy and an unknown word are ignored
    send_record(count_record(1'b0, REC_COUNT_OPEN, 16'sd2));
    send_record(count_record(1'b0, REC_COUNT_CLOSED, 16'sd7));
    send_record(knot_record(REC_KNOT_OPEN_LINKED, 10, 20, 30, 40, 30, 40));
    send_record(count_record(1'b0, REC_UNKNOWN_TOP, 16'sd1));
    send_record(knot_record(REC_KNOT_CLOSED_FREE, 50, 60, 70, 80, 90, 100));
    // one knot gives both the move and the close
    send_record(count_record(1'b0, REC_COUNT_CLOSED, 16'sd1));
    send_record(knot_record(REC_KNOT_OPEN_FREE, COORD_MIN, COORD_MAX, 20, 30,
                            COORD_MAX, COORD_MIN));
    // a new block abandons a long subpath left open
    send_record(count_record(1'b0, REC_COUNT_OPEN, 16'sd32767));
    send_record(knot_record(REC_KNOT_CLOSED_LINKED, 1, 1, 2, 2, 3, 3));
    send_record(knot_record(REC_KNOT_OPEN_LINKED, 4, 4, 4, 4, 5, 5));
    rec = knot_record(REC_KNOT_OPEN_FREE, 6, 6, 7, 7, 8, 8);
    rec.new_block = 1'b1;
    send_record(rec);
    send_record(count_record(1'b1, REC_COUNT_CLOSED, 16'sd2));
    send_record(knot_record(REC_KNOT_CLOSED_FREE, 9, 9, 9, 9, 10, 11));
    send_record(knot_record(REC_KNOT_OPEN_LINKED, 12, 13, 14, 15, 14, 15));
    wait_drain();
  endtask

  // Largest sizes, zero sizes (every point on the origin) and mixed sizes
  task automatic test_scale_extremes();
    int sent;
    set_scale(16'hFFFF, 16'hFFFF);
    send_record(count_record(1'b1, REC_COUNT_CLOSED, 16'sd2));
    send_record(knot_record(REC_KNOT_CLOSED_LINKED, COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN,
                            COORD_MAX, COORD_MIN));
    send_record(knot_record(REC_KNOT_OPEN_LINKED, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX,
                            COORD_MIN, COORD_MAX));
    set_scale(16'd0, 16'd0);
    send_subpath(3, 0, sent);
    set_scale(16'd1, 16'hFFFF);
    send_subpath(4, 30, sent);
    set_scale(16'hFFFF, 16'd0);
    send_subpath(3, 0, sent);
  endtask

  // Random subpaths and noise under one scale; halfway, pause the sender
  // until every word is back
  task automatic test_random_paths(input logic [15:0] width, input logic [15:0] height,
                                   input bit idle, input int quota);
    int done;
    int sent;
    bit paused;
    done = 0;
    paused = 1'b0;
    set_scale(width, height);
    idling_on = idle;
    while (done < quota) begin
      if ($urandom_range(0, 9) == 0) begin
        send_record(random_record());
      end else begin
        send_subpath(pick_path_length(), $urandom_range(10, 70), sent);
        done += sent;
      end
      if (!paused && done >= quota / 2) begin
        wait_drain();
        paused = 1'b1;
      end
    end
    wait_drain();
    idling_on = 1'b1;
  endtask

  // Hold the segment side off for a long stretch while records keep coming,
  // so the queue fills and the record side stalls
  task automatic test_backpressure();
    int sent;
    set_scale(16'($urandom_range(1, 65535)), 16'($urandom_range(1, 65535)));
    idling_on = 1'b0;
    hold_request = 1'b1;
    while (!hold_active) @(posedge clk);
    repeat (6) send_subpath($urandom_range(2, 6), 40, sent);
    wait_drain();
    idling_on = 1'b1;
  endtask

  initial begin : run_tests
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed_shapes();
    test_special_cases();
    test_scale_extremes();
    test_random_paths(16'd1, 16'd1, 1'b1, 240);
    test_random_paths(16'hFFFF, 16'd1, 1'b0, 200);
    test_backpressure();
    test_random_paths(16'($urandom_range(1, 65535)), 16'($urandom_range(1, 65535)), 1'b1, 240);
    test_random_paths(16'd1, 16'hFFFF, 1'b1, 240);
    test_random_paths(16'($urandom_range(1, 16)), 16'($urandom_range(1, 16)), 1'b1, 240);
    wait_drain();
    if (failures == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

  // Give up well beyond the slowest correct run
  initial begin : watchdog
    #4000000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
